// File: design/arc_pkg.sv
// Shared types, constants and encodings for the AArch64 code relocator.
package arc_pkg;

   localparam int WORD_W    = 32;
   localparam int INDEX_W   = 30;
   localparam int ADDR_W    = 64;
   localparam int SIZE_W    = 32;
   localparam int CSR_IDX_W = 3;

   localparam logic [WORD_W-1:0] B_MASK      = 32'hFC00_0000;
   localparam logic [WORD_W-1:0] BL_MATCH    = 32'h9400_0000;
   localparam logic [WORD_W-1:0] B_MATCH     = 32'h1400_0000;
   localparam logic [WORD_W-1:0] BCOND_MASK  = 32'hFF00_0010;
   localparam logic [WORD_W-1:0] BCOND_MATCH = 32'h5400_0000;
   localparam logic [WORD_W-1:0] ADRP_MASK   = 32'h9F00_0000;
   localparam logic [WORD_W-1:0] ADRP_MATCH  = 32'h9000_0000;
   localparam logic [ADDR_W-1:0] PAGE_MASK   = 64'hFFFF_FFFF_FFFF_F000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SRC_CODE_BASE = 3'd0,
      CSR_DST_CODE_BASE = 3'd1,
      CSR_CODE_BYTES    = 3'd2,
      CSR_OLD_DATA_BASE = 3'd3,
      CSR_NEW_DATA_BASE = 3'd4,
      CSR_DATA_BYTES    = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      CLS_OTHER  = 2'd0,
      CLS_BRANCH = 2'd1,
      CLS_COND   = 2'd2,
      CLS_ADRP   = 2'd3
   } instr_class_type;

   // code_delta = src_code_base - dst_code_base, data_delta = new_data_base - old_data_base
   typedef struct packed {
      logic [ADDR_W-1:0] src_code_base;
      logic [ADDR_W-1:0] dst_code_base;
      logic [SIZE_W-1:0] code_bytes;
      logic [ADDR_W-1:0] old_data_base;
      logic [SIZE_W-1:0] data_bytes;
      logic [ADDR_W-1:0] code_delta;
      logic [ADDR_W-1:0] data_delta;
   } cfg_type;

   typedef struct packed {
      logic              valid;
      logic [WORD_W-1:0] word;
      logic [31:0]       idx4;
      logic [ADDR_W-1:0] spc_page;
      logic [ADDR_W-1:0] dpc_page;
   } stage_type;

   // offset from region base is inside a region of the given size
   function automatic logic in_region(input logic [ADDR_W-1:0] rel,
                                      input logic [SIZE_W-1:0] size);
      in_region = (rel[ADDR_W-1:SIZE_W] == '0) && (rel[SIZE_W-1:0] < size);
   endfunction

endpackage

// File: design/arc_if.sv
// Request, response and register-write channel interfaces.
interface arc_req_if import arc_pkg::*;;
   logic               valid;
   logic               ready;
   logic [WORD_W-1:0]  instr_word;
   logic [INDEX_W-1:0] word_index;
   modport source (output valid, output instr_word, output word_index, input ready);
   modport sink   (input valid, input instr_word, input word_index, output ready);
endinterface

interface arc_rsp_if import arc_pkg::*;;
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] new_word;
   logic [1:0]        instr_class;
   logic              rewritten;
   logic              out_of_range;
   modport source (output valid, output new_word, output instr_class, output rewritten,
                   output out_of_range, input ready);
   modport sink   (input valid, input new_word, input instr_class, input rewritten,
                   input out_of_range, output ready);
endinterface

interface arc_csr_if import arc_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] reg_index;
   logic [ADDR_W-1:0]    wr_data;
   modport source (output valid, output reg_index, output wr_data, input ready);
   modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

// File: design/arc_csr_regs.sv
// Relocation configuration registers and precomputed base deltas.
module arc_csr_regs import arc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   arc_csr_if.sink    csr,
   output cfg_type    cfg
);

   logic [ADDR_W-1:0] src_code_base_ff;
   logic [ADDR_W-1:0] dst_code_base_ff;
   logic [SIZE_W-1:0] code_bytes_ff;
   logic [ADDR_W-1:0] old_data_base_ff;
   logic [ADDR_W-1:0] new_data_base_ff;
   logic [SIZE_W-1:0] data_bytes_ff;
   logic [ADDR_W-1:0] code_delta_ff;
   logic [ADDR_W-1:0] data_delta_ff;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_code_base_ff <= '0;
         dst_code_base_ff <= '0;
         code_bytes_ff    <= '0;
         old_data_base_ff <= '0;
         new_data_base_ff <= '0;
         data_bytes_ff    <= '0;
         code_delta_ff    <= '0;
         data_delta_ff    <= '0;
      end else begin
         code_delta_ff <= src_code_base_ff - dst_code_base_ff;
         data_delta_ff <= new_data_base_ff - old_data_base_ff;
         if (csr.valid) begin
            unique case (csr_index_type'(csr.reg_index))
               CSR_SRC_CODE_BASE: src_code_base_ff <= csr.wr_data;
               CSR_DST_CODE_BASE: dst_code_base_ff <= csr.wr_data;
               CSR_CODE_BYTES:    code_bytes_ff    <= csr.wr_data[SIZE_W-1:0];
               CSR_OLD_DATA_BASE: old_data_base_ff <= csr.wr_data;
               CSR_NEW_DATA_BASE: new_data_base_ff <= csr.wr_data;
               CSR_DATA_BYTES:    data_bytes_ff    <= csr.wr_data[SIZE_W-1:0];
               default: ;
            endcase
         end
      end
   end

   assign cfg.src_code_base = src_code_base_ff;
   assign cfg.dst_code_base = dst_code_base_ff;
   assign cfg.code_bytes    = code_bytes_ff;
   assign cfg.old_data_base = old_data_base_ff;
   assign cfg.data_bytes    = data_bytes_ff;
   assign cfg.code_delta    = code_delta_ff;
   assign cfg.data_delta    = data_delta_ff;

endmodule

// File: design/arc_pc_stage.sv
// Input stage: captures the request and the source and destination pc pages.
module arc_pc_stage import arc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   arc_req_if.sink    req,
   input  cfg_type    cfg,
   input  logic       out_open,
   output stage_type  s1
);

   logic              valid_ff, valid_in;
   logic [WORD_W-1:0] word_ff;
   logic [31:0]       idx4_ff, idx4_in;
   logic [ADDR_W-1:0] spc_page_ff, spc_page_in;
   logic [ADDR_W-1:0] dpc_page_ff, dpc_page_in;
   logic              load;

   assign req.ready = !valid_ff || out_open;
   assign load      = req.valid && req.ready;
   assign valid_in  = load || (valid_ff && !out_open);

   assign idx4_in     = {req.word_index, 2'b00};
   assign spc_page_in = (cfg.src_code_base + {32'b0, idx4_in}) & PAGE_MASK;
   assign dpc_page_in = (cfg.dst_code_base + {32'b0, idx4_in}) & PAGE_MASK;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff     <= req.instr_word;
         idx4_ff     <= idx4_in;
         spc_page_ff <= spc_page_in;
         dpc_page_ff <= dpc_page_in;
      end
   end

   assign s1.valid    = valid_ff;
   assign s1.word     = word_ff;
   assign s1.idx4     = idx4_ff;
   assign s1.spc_page = spc_page_ff;
   assign s1.dpc_page = dpc_page_ff;

   // a held request keeps its word while the output side is blocked
   a_hold: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !out_open |=> valid_ff && $stable(word_ff))
      else $error("stage request dropped while stalled");

endmodule

// File: design/arc_rewrite.sv
// Decode, region tests, immediate re-encoding and the response register.
module arc_rewrite import arc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  stage_type  s1,
   input  cfg_type    cfg,
   output logic       out_open,
   arc_rsp_if.source  rsp
);

   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] new_word_ff, new_word_in;
   instr_class_type   class_ff, class_in;
   logic              rewritten_ff, rewritten_in;
   logic              oor_ff, oor_in;
   logic              take;

   logic              is_adrp, is_b, is_cond;
   logic [WORD_W-1:0] w;
   logic [ADDR_W-1:0] br_off, cond_off, off_sel;
   logic [ADDR_W-1:0] br_rel, br_diff;
   logic              br_inside;
   logic [ADDR_W-1:0] adrp_off, d_rel, pg_off;
   logic              d_inside;

   assign out_open     = !rsp_valid_ff || rsp.ready;
   assign take         = s1.valid && out_open;
   assign rsp_valid_in = take || (rsp_valid_ff && !rsp.ready);

   assign w       = s1.word;
   assign is_adrp = (w & ADRP_MASK) == ADRP_MATCH;
   assign is_b    = ((w & B_MASK) == BL_MATCH) || ((w & B_MASK) == B_MATCH);
   assign is_cond = (w & BCOND_MASK) == BCOND_MATCH;

   // branch targets relative to the source base and to the destination pc
   assign br_off    = {{36{w[25]}}, w[25:0], 2'b00};
   assign cond_off  = {{43{w[23]}}, w[23:5], 2'b00};
   assign off_sel   = is_b ? br_off : cond_off;
   assign br_rel    = {32'b0, s1.idx4} + off_sel;
   assign br_inside = in_region(br_rel, cfg.code_bytes);
   assign br_diff   = cfg.code_delta + off_sel;

   // page target relative to the source data base, new page offset
   assign adrp_off = {{31{w[23]}}, w[23:5], w[30:29], 12'b0};
   assign d_rel    = s1.spc_page - cfg.old_data_base + adrp_off;
   assign d_inside = in_region(d_rel, cfg.data_bytes);
   assign pg_off   = cfg.data_delta + (s1.spc_page - s1.dpc_page) + adrp_off;

   always_comb begin
      new_word_in  = w;
      class_in     = CLS_OTHER;
      rewritten_in = 1'b0;
      oor_in       = 1'b0;
      if (is_adrp) begin
         class_in = CLS_ADRP;
         if (d_inside) begin
            new_word_in  = {w[31], pg_off[13:12], w[28:24], pg_off[32:14], w[4:0]};
            rewritten_in = 1'b1;
            oor_in       = !((&pg_off[63:32]) || !(|pg_off[63:32]));
         end
      end else if (is_b) begin
         class_in = CLS_BRANCH;
         if (!br_inside) begin
            new_word_in  = {w[31:26], br_diff[27:2]};
            rewritten_in = 1'b1;
            oor_in       = !((&br_diff[63:27]) || !(|br_diff[63:27]));
         end
      end else if (is_cond) begin
         class_in = CLS_COND;
         if (!br_inside) begin
            new_word_in  = {w[31:24], br_diff[20:2], w[4:0]};
            rewritten_in = 1'b1;
            oor_in       = !((&br_diff[63:20]) || !(|br_diff[63:20]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         new_word_ff  <= new_word_in;
         class_ff     <= class_in;
         rewritten_ff <= rewritten_in;
         oor_ff       <= oor_in;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.new_word     = new_word_ff;
   assign rsp.instr_class  = class_ff;
   assign rsp.rewritten    = rewritten_ff;
   assign rsp.out_of_range = oor_ff;

   a_oor_rw: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && oor_ff |-> rewritten_ff)
      else $error("out_of_range without rewrite");

   a_rw_cls: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rewritten_ff |-> class_ff != CLS_OTHER)
      else $error("rewrite of an unrecognized word");

   a_pass: assert property (@(posedge clock) disable iff (reset)
      take && !is_adrp && !is_b && !is_cond |=> new_word_ff == $past(w))
      else $error("unrecognized word was altered");

endmodule

// File: design/arm64_code_relocator.sv
// Top level of the AArch64 code relocator.
// Throughput: one request per cycle while rsp.ready is high; two pipeline
// registers: pc stage, then response, which takes the request when it is open.
// A blocked response holds the pc stage; req.ready then follows rsp.ready.
// Reset clears both valid flags and all configuration registers to zero.
module arm64_code_relocator import arc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   arc_req_if.sink    req,
   arc_rsp_if.source  rsp,
   arc_csr_if.sink    csr
);

   cfg_type   cfg;
   stage_type s1;
   logic      out_open;

   arc_csr_regs u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr),
      .cfg   (cfg)
   );

   arc_pc_stage u_pc (
      .clock    (clock),
      .reset    (reset),
      .req      (req),
      .cfg      (cfg),
      .out_open (out_open),
      .s1       (s1)
   );

   arc_rewrite u_rw (
      .clock    (clock),
      .reset    (reset),
      .s1       (s1),
      .cfg      (cfg),
      .out_open (out_open),
      .rsp      (rsp)
   );

endmodule
